// File: hw/rtl/comds_pkg.sv
package comds_pkg;

    localparam int ID_W      = 12;
    localparam int POS_W     = 32;
    localparam int MASS_W    = 24;
    localparam int SUM_W     = 64;
    localparam int TMASS_W   = 31;
    localparam int PROD_W    = POS_W + MASS_W + 1;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 208;
    localparam int S_PAD_W   = S_TDATA_W - (ID_W + 3 * POS_W + MASS_W);
    localparam int M_PAD_W   = M_TDATA_W - (ID_W + 6 * POS_W);
    localparam int DIV_CNT_W = $clog2(POS_W);

    typedef logic [ID_W-1:0]           atom_id_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic [MASS_W-1:0]         mass_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [TMASS_W-1:0]        tmass_t;

    typedef struct packed {
        atom_id_t id;
        pos_t     x;
        pos_t     y;
        pos_t     z;
    } atom_t;

    typedef struct packed {
        logic load;
        logic clear;
    } acc_ctl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    function automatic pos_t sat_sub(pos_t a, pos_t b);
        logic signed [POS_W:0] d;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        if (d[POS_W] != d[POS_W-1]) begin
            return d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return d[POS_W-1:0];
    endfunction

endpackage

// File: hw/rtl/comds_acc.sv
module comds_acc (
    input  logic               aclk,
    input  logic               aresetn,
    input  comds_pkg::acc_ctl_t ctl,
    input  comds_pkg::pos_t    pos_x,
    input  comds_pkg::pos_t    pos_y,
    input  comds_pkg::pos_t    pos_z,
    input  comds_pkg::mass_t   mass,
    output comds_pkg::sum_t    sum_x,
    output comds_pkg::sum_t    sum_y,
    output comds_pkg::sum_t    sum_z,
    output comds_pkg::tmass_t  total_mass
);
    import comds_pkg::*;

    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    mass_t                    mass_reg;
    logic                     prod_vld_reg;
    sum_t                     sum_x_reg;
    sum_t                     sum_y_reg;
    sum_t                     sum_z_reg;
    tmass_t                   total_mass_reg;

    // multiply stage
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_x_reg <= pos_x * $signed({1'b0, mass});
            prod_y_reg <= pos_y * $signed({1'b0, mass});
            prod_z_reg <= pos_z * $signed({1'b0, mass});
            mass_reg   <= mass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.load;
        end
    end

    // accumulate stage
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_z_reg      <= '0;
            total_mass_reg <= '0;
        end else if (prod_vld_reg) begin
            sum_x_reg      <= sum_x_reg + SUM_W'(prod_x_reg);
            sum_y_reg      <= sum_y_reg + SUM_W'(prod_y_reg);
            sum_z_reg      <= sum_z_reg + SUM_W'(prod_z_reg);
            total_mass_reg <= total_mass_reg + TMASS_W'(mass_reg);
        end
    end

    assign sum_x      = sum_x_reg;
    assign sum_y      = sum_y_reg;
    assign sum_z      = sum_z_reg;
    assign total_mass = total_mass_reg;

endmodule

// File: hw/rtl/comds_div.sv
module comds_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  comds_pkg::sum_t   dividend,
    input  comds_pkg::tmass_t divisor,
    output logic              done,
    output comds_pkg::pos_t   quotient
);
    import comds_pkg::*;

    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    tmass_t               rem_reg;
    logic [POS_W-1:0]     mag_reg;
    tmass_t               d_reg;
    pos_t                 q_reg;

    sum_t             mag_full;
    logic [TMASS_W:0] trial;
    logic [TMASS_W:0] diff;
    logic             take;

    // quotient magnitude stays below 2^32, so the top half starts below the divisor
    always_comb begin
        mag_full = dividend[SUM_W-1] ? -dividend : dividend;
        trial    = {rem_reg, mag_reg[POS_W-1]};
        diff     = trial - {1'b0, d_reg};
        take     = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == DIV_CNT_W'(POS_W - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            neg_reg <= dividend[SUM_W-1];
            rem_reg <= mag_full[POS_W+TMASS_W-1:POS_W];
            mag_reg <= mag_full[POS_W-1:0];
            d_reg   <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= take ? diff[TMASS_W-1:0] : trial[TMASS_W-1:0];
            mag_reg <= {mag_reg[POS_W-2:0], take};
        end
        if (fin_reg) begin
            q_reg <= neg_reg ? pos_t'(-mag_reg) : pos_t'(mag_reg);
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: hw/rtl/center_of_mass_subtract.sv
// Loads up to MAX_ATOMS atoms, one request per cycle, into an on-chip store while a
// multiply-accumulate pipeline sums mass times position per axis and the total mass.
// After the request marked tlast the block takes no request until the final result of
// the group has been loaded into the output register: the accumulator drains in the
// ST_DRAIN state, then three bit-serial dividers (one quotient bit per cycle, then a
// final step that applies the sign) produce the center of mass, truncated toward zero.
// The stored atoms then leave in load order, each moving from the store's registered
// read into the output register; the next atom is read only after the output register
// has accepted the current one.
// Each result carries the position minus the center (saturated), the center itself,
// and tuser high when the total mass was zero, in which case the center is zero and
// positions pass through. Atoms beyond MAX_ATOMS in one group are dropped; a dropped
// atom marked tlast still closes the group.
module center_of_mass_subtract #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // atom_id, pos_x, pos_y, pos_z, mass, zero pad
    input  logic [comds_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_atom_id, centered_x, centered_y, centered_z, com_x, com_y, com_z, zero pad
    output logic [comds_pkg::M_TDATA_W-1:0] m_tdata,
    // zero_mass
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import comds_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
    localparam int ADDR_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             zero_reg;

    atom_t mem [MAX_ATOMS];
    atom_t rdata_reg;
    atom_t wdata;

    acc_ctl_t acc_ctl;
    logic     s_accept;
    logic     room;
    logic     div_start;
    logic     mem_re;
    logic     out_free;
    logic     out_load;
    logic     emit_last;

    sum_t     sum_x, sum_y, sum_z;
    tmass_t   total_mass;
    logic [2:0] div_done;
    pos_t     q_x, q_y, q_z;
    pos_t     c_x, c_y, c_z;

    logic     m_tvalid_reg;
    atom_id_t out_id_reg;
    pos_t     cen_x_reg, cen_y_reg, cen_z_reg;
    pos_t     com_x_reg, com_y_reg, com_z_reg;
    logic     zero_out_reg;
    logic     last_out_reg;

    // input field unpack
    always_comb begin
        wdata.id = s_tdata[ID_W-1:0];
        wdata.x  = s_tdata[ID_W+POS_W-1:ID_W];
        wdata.y  = s_tdata[ID_W+2*POS_W-1:ID_W+POS_W];
        wdata.z  = s_tdata[ID_W+3*POS_W-1:ID_W+2*POS_W];
    end

    comds_acc u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (acc_ctl),
        .pos_x      (wdata.x),
        .pos_y      (wdata.y),
        .pos_z      (wdata.z),
        .mass       (s_tdata[ID_W+3*POS_W+MASS_W-1:ID_W+3*POS_W]),
        .sum_x      (sum_x),
        .sum_y      (sum_y),
        .sum_z      (sum_z),
        .total_mass (total_mass)
    );

    comds_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_x),
        .divisor  (total_mass),
        .done     (div_done[0]),
        .quotient (q_x)
    );

    comds_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_y),
        .divisor  (total_mass),
        .done     (div_done[1]),
        .quotient (q_y)
    );

    comds_div u_div_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_z),
        .divisor  (total_mass),
        .done     (div_done[2]),
        .quotient (q_z)
    );

    // atom store
    always_ff @(posedge aclk) begin
        if (acc_ctl.load) begin
            mem[count_reg[ADDR_W-1:0]] <= wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // control outputs
    always_comb begin
        s_tready      = (state_reg == ST_LOAD);
        s_accept      = s_tvalid && s_tready;
        room          = (count_reg < CNT_W'(MAX_ATOMS));
        acc_ctl.load  = s_accept && room;
        acc_ctl.clear = (state_reg == ST_DIV_GO);
        div_start     = (state_reg == ST_DIV_GO);
        mem_re        = (state_reg == ST_EMIT_RD);
        out_free      = !m_tvalid_reg || m_tready;
        out_load      = (state_reg == ST_EMIT_WR) && out_free;
        emit_last     = (CNT_W'(idx_reg + 1'b1) == count_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (&div_done) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (acc_ctl.load) begin
            count_next = count_reg + 1'b1;
        end
        if (out_load) begin
            idx_next = emit_last ? '0 : CNT_W'(idx_reg + 1'b1);
            if (emit_last) begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            zero_reg <= (total_mass == '0);
        end
    end

    always_comb begin
        c_x = zero_reg ? '0 : q_x;
        c_y = zero_reg ? '0 : q_y;
        c_z = zero_reg ? '0 : q_z;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_id_reg   <= rdata_reg.id;
            cen_x_reg    <= sat_sub(rdata_reg.x, c_x);
            cen_y_reg    <= sat_sub(rdata_reg.y, c_y);
            cen_z_reg    <= sat_sub(rdata_reg.z, c_z);
            com_x_reg    <= c_x;
            com_y_reg    <= c_y;
            com_z_reg    <= c_z;
            zero_out_reg <= zero_reg;
            last_out_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, com_z_reg, com_y_reg, com_x_reg,
                       cen_z_reg, cen_y_reg, cen_x_reg, out_id_reg};
    assign m_tuser  = zero_out_reg;
    assign m_tlast  = last_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ATOMS))
        else $error("atom count beyond store depth");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done == 3'b000) || (div_done == 3'b111))
        else $error("dividers out of step");

    a_group_close: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && emit_last |=> (state_reg == ST_LOAD) && (count_reg == '0))
        else $error("group not closed after final result");

    a_zero_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && zero_out_reg |->
            (com_x_reg == '0) && (com_y_reg == '0) && (com_z_reg == '0))
        else $error("nonzero center with zero total mass");

endmodule

// File: bench/tb_center_of_mass_subtract.sv
`timescale 1ns / 1ps

module tb_center_of_mass_subtract;
    import comds_pkg::*;

    localparam int    MAX_ATOMS = 64;
    localparam int    MAX_GAP   = 14;
    localparam sum_t  SAT_HI    = 64'sd2147483647;
    localparam sum_t  SAT_LO    = -64'sd2147483648;
    localparam pos_t  POS_MAX   = 32'h7fff_ffff;
    localparam pos_t  POS_MIN   = 32'h8000_0000;
    localparam mass_t MASS_MAX  = 24'hff_ffff;

    typedef struct {
        atom_id_t id;
        pos_t     cen_x;
        pos_t     cen_y;
        pos_t     cen_z;
        pos_t     com_x;
        pos_t     com_y;
        pos_t     com_z;
        logic     zero;
        logic     last;
    } centered_atom_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // group being loaded
    atom_t          held_atoms[$];
    sum_t           wsum_x;
    sum_t           wsum_y;
    sum_t           wsum_z;
    tmass_t         mass_total;

    centered_atom_t centered_due[$];

    bit send_idle  = 1'b0;
    bit recv_idle  = 1'b0;
    int recv_wait  = 0;
    int recv_draw  = 0;

    int fail_count    = 0;
    int atoms_sent    = 0;
    int atoms_dropped = 0;
    int groups_closed = 0;
    int zero_groups   = 0;
    int saturations   = 0;
    int results_seen  = 0;
    int results_paced = 0;

    center_of_mass_subtract #(
        .MAX_ATOMS(MAX_ATOMS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic pos_t clamp_diff(input pos_t p, input pos_t c);
        sum_t d;
        d = sum_t'(p) - sum_t'(c);
        if (d > SAT_HI) begin
            saturations++;
            return POS_MAX;
        end
        if (d < SAT_LO) begin
            saturations++;
            return POS_MIN;
        end
        return d[POS_W-1:0];
    endfunction

    task automatic track_atom(input atom_t a, input mass_t m, input logic last);
        sum_t           tm;
        sum_t           cx;
        sum_t           cy;
        sum_t           cz;
        logic           zero;
        centered_atom_t r;
        if (held_atoms.size() < MAX_ATOMS) begin
            held_atoms.push_back(a);
            wsum_x += sum_t'(a.x) * sum_t'(m);
            wsum_y += sum_t'(a.y) * sum_t'(m);
            wsum_z += sum_t'(a.z) * sum_t'(m);
            mass_total += m;
        end else begin
            atoms_dropped++;
        end
        if (!last) return;
        zero = (mass_total == '0);
        tm = sum_t'(mass_total);
        if (zero) begin
            cx = '0;
            cy = '0;
            cz = '0;
        end else begin
            // signed divide truncates toward zero
            cx = wsum_x / tm;
            cy = wsum_y / tm;
            cz = wsum_z / tm;
        end
        foreach (held_atoms[k]) begin
            r.id    = held_atoms[k].id;
            r.cen_x = clamp_diff(held_atoms[k].x, cx[POS_W-1:0]);
            r.cen_y = clamp_diff(held_atoms[k].y, cy[POS_W-1:0]);
            r.cen_z = clamp_diff(held_atoms[k].z, cz[POS_W-1:0]);
            r.com_x = cx[POS_W-1:0];
            r.com_y = cy[POS_W-1:0];
            r.com_z = cz[POS_W-1:0];
            r.zero  = zero;
            r.last  = (k == held_atoms.size() - 1);
            centered_due.push_back(r);
        end
        if (zero) zero_groups++;
        groups_closed++;
        held_atoms.delete();
        wsum_x     = '0;
        wsum_y     = '0;
        wsum_z     = '0;
        mass_total = '0;
    endtask

    // called and returns at a falling edge
    task automatic send_atom(input atom_id_t id, input pos_t x, input pos_t y, input pos_t z,
                             input mass_t m, input logic last);
        atom_t a;
        int    gap;
        a.id = id;
        a.x  = x;
        a.y  = y;
        a.z  = z;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {{S_PAD_W{1'b0}}, m, z, y, x, id};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_atom(a, m, last);
        atoms_sent++;
        @(negedge aclk);
    endtask

    function automatic pos_t pick_pos(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 2 * 1048576) - 1048576;
            2: begin
                case ($urandom_range(0, 3))
                    0: return POS_MAX;
                    1: return POS_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            // near the rails, to push the subtraction into saturation
            default: return $urandom_range(0, 1) ? POS_MAX - $urandom_range(0, 255)
                                                 : POS_MIN + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic mass_t pick_mass(input int style);
        case (style)
            0, 1, 2, 3: return $urandom;
            4, 5: return $urandom_range(0, 15);
            6: return '0;
            7: return $urandom_range(0, 1) ? MASS_MAX : '0;
            default: return ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(1, 4095);
        endcase
    endfunction

    task automatic send_random_group(input int n);
        int pos_style;
        int mass_style;
        pos_style  = $urandom_range(0, 3);
        mass_style = $urandom_range(0, 9);
        send_idle  = ($urandom_range(0, 3) != 0);
        recv_idle  = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++) begin
            send_atom($urandom, pick_pos(pos_style), pick_pos(pos_style), pick_pos(pos_style),
                      pick_mass(mass_style), i == n - 1);
        end
    endtask

    task automatic test_extremes();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_atom(12'hfff, POS_MAX, POS_MIN, '0, MASS_MAX, 1'b1);
        send_atom(12'h000, POS_MIN, POS_MAX, '1, 24'h000001, 1'b1);
        send_atom(12'h5a5, POS_MAX, POS_MIN, 32'h5555_aaaa, MASS_MAX, 1'b0);
        send_atom(12'ha5a, POS_MIN, POS_MAX, 32'haaaa_5555, MASS_MAX, 1'b1);
    endtask

    task automatic test_zero_mass();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_atom(12'h011, POS_MAX, 32'h0001_8000, POS_MIN, '0, 1'b0);
        send_atom(12'h022, POS_MIN, '1, POS_MAX, '0, 1'b0);
        send_atom(12'h033, 32'h1234_5678, 32'hfedc_ba98, '0, '0, 1'b1);
    endtask

    task automatic test_truncation();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        // negative quotients must round toward zero, not down
        send_atom(12'h101, -32'sd5, 32'sd5, -32'sd7, 24'd2, 1'b0);
        send_atom(12'h102, '0, -32'sd1, '0, 24'd1, 1'b1);
    endtask

    task automatic test_saturation();
        send_idle = 1'b1;
        recv_idle = 1'b0;
        send_atom(12'h201, POS_MAX, POS_MIN, '0, 24'd1, 1'b0);
        send_atom(12'h202, POS_MIN, POS_MAX, '0, MASS_MAX, 1'b1);
        send_atom(12'h203, POS_MIN, POS_MAX, POS_MAX, 24'd1, 1'b0);
        send_atom(12'h204, POS_MAX, POS_MIN, POS_MIN, MASS_MAX, 1'b1);
    endtask

    task automatic test_overflow();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        for (int i = 0; i < MAX_ATOMS; i++) begin
            send_atom(i, pick_pos(1), pick_pos(1), pick_pos(0), pick_mass(4), 1'b0);
        end
        // both extra atoms are dropped, the last one still closes the group
        send_atom(12'h7ff, POS_MAX, POS_MAX, POS_MAX, MASS_MAX, 1'b0);
        send_atom(12'h800, POS_MIN, POS_MIN, POS_MIN, MASS_MAX, 1'b1);
    endtask

    task automatic test_random_groups();
        int start;
        int r;
        int n;
        start = atoms_sent;
        while (atoms_sent < start + 170) begin
            r = $urandom_range(0, 99);
            if (r < 80) n = $urandom_range(1, 8);
            else if (r < 96) n = $urandom_range(9, 40);
            else n = $urandom_range(60, 70);
            send_random_group(n);
        end
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        centered_atom_t e;
        if (aresetn && m_tvalid && m_tready) begin
            recv_draw = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            results_seen++;
            if (centered_due.size() == 0) begin
                $error("result with no atom awaiting output, id %0h", m_tdata[ID_W-1:0]);
                fail_count++;
            end else begin
                e = centered_due.pop_front();
                check_field("out_atom_id", e.id, m_tdata[ID_W-1:0]);
                check_field("centered_x", e.cen_x, m_tdata[ID_W +: POS_W]);
                check_field("centered_y", e.cen_y, m_tdata[ID_W + POS_W +: POS_W]);
                check_field("centered_z", e.cen_z, m_tdata[ID_W + 2 * POS_W +: POS_W]);
                check_field("com_x", e.com_x, m_tdata[ID_W + 3 * POS_W +: POS_W]);
                check_field("com_y", e.com_y, m_tdata[ID_W + 4 * POS_W +: POS_W]);
                check_field("com_z", e.com_z, m_tdata[ID_W + 5 * POS_W +: POS_W]);
                check_field("zero_mass", e.zero, m_tuser);
                check_field("out_last", e.last, m_tlast);
            end
        end
    end

    always @(negedge aclk) begin
        if (results_seen != results_paced) begin
            results_paced = results_seen;
            recv_wait     = recv_draw;
        end
        if (recv_wait > 0) begin
            m_tready <= 1'b0;
            recv_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        wsum_x     = '0;
        wsum_y     = '0;
        wsum_z     = '0;
        mass_total = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_zero_mass();
        test_truncation();
        test_saturation();
        test_overflow();
        test_random_groups();

        s_tvalid <= 1'b0;
        while (centered_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("loaded %0d atoms in %0d groups, %0d dropped at capacity, %0d zero-mass groups",
                 atoms_sent, groups_closed, atoms_dropped, zero_groups);
        $display("checked %0d centered atoms, %0d axis values clamped", results_seen, saturations);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", centered_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/comds_pkg.sv
hw/rtl/comds_acc.sv
hw/rtl/comds_div.sv
hw/rtl/center_of_mass_subtract.sv
bench/tb_center_of_mass_subtract.sv
